[sv/llv_pkg.sv]
package llv_pkg;

    // Data format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Unit axis components lie in [-1.0, 1.0]: two bits above the fraction
    localparam int AXW  = FRAC_BITS + 2;
    // Eye/target difference keeps one extra bit
    localparam int DW1  = DATA_WIDTH + 1;
    // Magnitudes entering the normaliser (full precision cross product)
    localparam int NMW  = DATA_WIDTH + FRAC_BITS + 2;
    // Multiplier operand and product widths, accumulator width
    localparam int MW   = DATA_WIDTH + 2;
    localparam int PW   = 2 * MW;
    localparam int ACW  = 64;
    // Square root working width and length width
    localparam int SQW  = 64;
    localparam int LENW = 32;
    // The largest normalised magnitude lies in [2^29, 2^30)
    localparam int NORM_HI_BIT = 30;
    localparam int NORM_LO_BIT = 29;
    localparam int NORM_BITS   = 30;
    localparam int SHIFT_STEP  = 8;
    // Quotient bits of one normalised component, divider working width
    localparam int QB  = FRAC_BITS + 2;
    localparam int RW  = NORM_BITS + LENW + 2 + FRAC_BITS - LENW + QB;
    localparam int DCW = $clog2(QB);

    localparam logic signed [ACW-1:0] DW_HI = (ACW'(1) << (DATA_WIDTH - 1)) - ACW'(1);
    localparam logic signed [ACW-1:0] DW_LO = -DW_HI - ACW'(1);
    localparam logic signed [ACW-1:0] ONE_A = ACW'(1) << FRAC_BITS;

    // One input item after the front end
    typedef struct packed {
        logic [2:0][DATA_WIDTH-1:0] eye;
        logic [2:0][DATA_WIDTH-1:0] up;
        logic [2:0][DW1-1:0]        dir;
    } t_item;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NMAX,
        B_NSHIFT,
        B_SQ,
        B_SQRT,
        B_DIVLD,
        B_DIV,
        B_NEXT,
        B_CROSS,
        B_CROSSLD,
        B_DOT,
        B_DONE
    } t_bstate;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [ACW-1:0] mag_acc(input logic signed [ACW-1:0] x);
        return x[ACW-1] ? ACW'(-x) : ACW'(x);
    endfunction

    // Drop the fraction, ties away from zero
    function automatic logic signed [ACW-1:0] round_frac(input logic signed [ACW-1:0] x);
        logic [ACW-1:0] m;
        m = (mag_acc(x) + (ACW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[ACW-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [ACW-1:0] x);
        logic signed [ACW-1:0] y;
        y = (x > DW_HI) ? DW_HI : ((x < DW_LO) ? DW_LO : x);
        return y[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [AXW-1:0] clamp_one(input logic signed [ACW-1:0] x);
        logic signed [ACW-1:0] y;
        y = (x > ONE_A) ? ONE_A : ((x < -ONE_A) ? -ONE_A : x);
        return y[AXW-1:0];
    endfunction

endpackage

[sv/llv_front.sv]
module llv_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [9*llv_pkg::DATA_WIDTH-1:0] i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output llv_pkg::t_item             o_item
);
    import llv_pkg::*;

    logic  r_hand;
    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Handedness register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hand <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_hand <= i_cfg_wr_data;
        end
    end

    // Unpack the item and form the view direction
    always_comb begin
        logic signed [DW1-1:0] e;
        logic signed [DW1-1:0] t;
        n_item = '0;
        for (int i = 0; i < 3; i++) begin
            n_item.eye[i] = i_data[i*DATA_WIDTH +: DATA_WIDTH];
            n_item.up[i]  = i_data[(6+i)*DATA_WIDTH +: DATA_WIDTH];
            e = DW1'($signed(i_data[i*DATA_WIDTH +: DATA_WIDTH]));
            t = DW1'($signed(i_data[(3+i)*DATA_WIDTH +: DATA_WIDTH]));
            n_item.dir[i] = r_hand ? e - t : t - e;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Holding stage in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[sv/llv_queue.sv]
module llv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  llv_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output llv_pkg::t_item o_item
);
    import llv_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    // Two-entry item queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[sv/llv_back.sv]
module llv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  llv_pkg::t_item                    i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_row,
    output logic                              o_last,
    output logic [4*llv_pkg::DATA_WIDTH-1:0]  o_data
);
    import llv_pkg::*;

    t_bstate r_state;
    t_bstate n_state;

    // Item registers
    logic signed [DATA_WIDTH-1:0] r_eye [3];
    logic signed [DATA_WIDTH-1:0] r_up  [3];
    logic signed [AXW-1:0]        r_fwd [3];
    logic signed [AXW-1:0]        r_rgt [3];
    logic signed [AXW-1:0]        r_upn [3];
    logic signed [ACW-1:0]        r_cr  [3];
    logic signed [DATA_WIDTH-1:0] r_tr  [3];

    // Normaliser registers
    logic [NMW-1:0] r_nm [3];
    logic           r_ns [3];
    logic [NMW-1:0] r_top;
    logic [SQW-1:0] r_sx;
    logic [SQW-1:0] r_res;
    logic [SQW-1:0] r_bit;
    logic [RW-1:0]  r_rem;
    logic [RW-1:0]  r_dvs;
    logic [QB-1:0]  r_q;
    logic [DCW-1:0] r_dcnt;

    // Sequencing and the shared multiplier
    logic                  r_phase;
    logic [1:0]            r_ia;
    logic [1:0]            r_ib;
    logic                  r_sub;
    logic signed [ACW-1:0] r_prod;
    logic signed [ACW-1:0] r_acc;

    // Output buffer
    logic                         r_ob_valid;
    logic [1:0]                   r_row;
    logic signed [AXW-1:0]        r_orgt [3];
    logic signed [AXW-1:0]        r_oupn [3];
    logic signed [AXW-1:0]        r_ofwd [3];
    logic signed [DATA_WIDTH-1:0] r_otr  [3];

    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic [1:0]            ia1;
    logic [1:0]            ia2;
    logic [1:0]            sel_a;
    logic [1:0]            sel_b;
    logic [NMW-1:0]        top;
    logic [SQW-1:0]        trial;
    logic                  ge;
    logic [QB-1:0]         q_next;
    logic signed [AXW-1:0] q_val;
    logic signed [ACW-1:0] acc_sum;
    logic signed [ACW-1:0] acc_dif;
    logic                  ob_free;

    assign ia1   = nxt3(r_ia);
    assign ia2   = nxt3(ia1);
    assign sel_a = r_ib[0] ? ia2 : ia1;
    assign sel_b = r_ib[0] ? ia1 : ia2;

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            B_SQ: begin
                mul_a = $signed({{(MW-NORM_BITS){1'b0}}, r_nm[r_ib][NORM_BITS-1:0]});
                mul_b = mul_a;
            end
            B_CROSS: begin
                if (!r_phase) begin
                    mul_a = MW'(r_up[sel_a]);
                    mul_b = MW'(r_fwd[sel_b]);
                end else begin
                    mul_a = MW'(r_fwd[sel_a]);
                    mul_b = MW'(r_rgt[sel_b]);
                end
            end
            B_DOT: begin
                mul_a = MW'(r_eye[r_ib]);
                case (r_ia)
                    2'd0:    mul_b = MW'(r_rgt[r_ib]);
                    2'd1:    mul_b = MW'(r_upn[r_ib]);
                    default: mul_b = MW'(r_fwd[r_ib]);
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign acc_sum = (r_ib == 2'd0) ? r_prod : r_acc + r_prod;
    assign acc_dif = r_acc - r_prod;

    // Largest magnitude, root step, divider step
    always_comb begin
        top = r_nm[0];
        if (r_nm[1] > top) top = r_nm[1];
        if (r_nm[2] > top) top = r_nm[2];
    end

    assign trial  = r_res + r_bit;
    assign ge     = (r_rem >= r_dvs);
    assign q_next = {r_q[QB-2:0], ge};
    assign q_val  = r_ns[r_ib] ? -$signed(AXW'(q_next)) : $signed(AXW'(q_next));

    assign ob_free = !r_ob_valid || (i_ready && r_row == 2'd3);
    assign o_ready = (r_state == B_IDLE);

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:    if (i_valid) n_state = B_NMAX;
            B_NMAX:    n_state = (top == '0) ? B_NEXT : B_NSHIFT;
            B_NSHIFT: begin
                if (r_top < (NMW'(1) << NORM_HI_BIT) && r_top >= (NMW'(1) << NORM_LO_BIT))
                    n_state = B_SQ;
            end
            B_SQ:      if (r_sub && r_ib == 2'd2) n_state = B_SQRT;
            B_SQRT:    if (r_bit == SQW'(1)) n_state = B_DIVLD;
            B_DIVLD:   n_state = B_DIV;
            B_DIV: begin
                if (r_dcnt == '0) n_state = (r_ib == 2'd2) ? B_NEXT : B_DIVLD;
            end
            B_NEXT:    n_state = B_CROSS;
            B_CROSS: begin
                if (r_sub && r_ib[0] && r_ia == 2'd2)
                    n_state = r_phase ? B_DOT : B_CROSSLD;
            end
            B_CROSSLD: n_state = B_NMAX;
            B_DOT:     if (r_sub && r_ib == 2'd2 && r_ia == 2'd2) n_state = B_DONE;
            B_DONE:    if (ob_free) n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_phase <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_eye[i] <= $signed(i_item.eye[i]);
                    r_up[i]  <= $signed(i_item.up[i]);
                    r_nm[i]  <= i_item.dir[i][DW1-1] ? NMW'(-$signed(i_item.dir[i]))
                                                     : NMW'(i_item.dir[i]);
                    r_ns[i]  <= i_item.dir[i][DW1-1];
                end
            end
            B_NMAX: begin
                r_top <= top;
                r_ib  <= 2'd0;
                r_sub <= 1'b0;
                if (top == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (!r_phase) r_fwd[i] <= '0;
                        else          r_rgt[i] <= '0;
                    end
                end
            end
            B_NSHIFT: begin
                // Bring the largest magnitude into [2^29, 2^30)
                if (r_top >= (NMW'(1) << (NORM_HI_BIT + SHIFT_STEP))) begin
                    r_top <= r_top >> SHIFT_STEP;
                    for (int i = 0; i < 3; i++) r_nm[i] <= r_nm[i] >> SHIFT_STEP;
                end else if (r_top >= (NMW'(1) << NORM_HI_BIT)) begin
                    r_top <= r_top >> 1;
                    for (int i = 0; i < 3; i++) r_nm[i] <= r_nm[i] >> 1;
                end else if (r_top < (NMW'(1) << (NORM_LO_BIT - SHIFT_STEP))) begin
                    r_top <= r_top << SHIFT_STEP;
                    for (int i = 0; i < 3; i++) r_nm[i] <= r_nm[i] << SHIFT_STEP;
                end else if (r_top < (NMW'(1) << NORM_LO_BIT)) begin
                    r_top <= r_top << 1;
                    for (int i = 0; i < 3; i++) r_nm[i] <= r_nm[i] << 1;
                end
            end
            B_SQ: begin
                // Sum of squares
                r_sub <= ~r_sub;
                if (!r_sub) begin
                    r_prod <= $signed(prod[ACW-1:0]);
                end else begin
                    r_acc <= acc_sum;
                    r_ib  <= r_ib + 2'd1;
                    if (r_ib == 2'd2) begin
                        r_sx  <= SQW'(acc_sum);
                        r_res <= '0;
                        r_bit <= SQW'(1) << (SQW - 2);
                    end
                end
            end
            B_SQRT: begin
                // One root bit per step
                if (r_sx >= trial) begin
                    r_sx  <= r_sx - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_ib  <= 2'd0;
            end
            B_DIVLD: begin
                r_rem  <= RW'({r_nm[r_ib][NORM_BITS-1:0], {FRAC_BITS{1'b0}}})
                          + RW'(r_res[LENW-1:1]);
                r_dvs  <= RW'(r_res[LENW-1:0]) << (QB - 1);
                r_q    <= '0;
                r_dcnt <= DCW'(QB - 1);
            end
            B_DIV: begin
                // Restoring division, one quotient bit per step
                if (ge) r_rem <= r_rem - r_dvs;
                r_dvs  <= r_dvs >> 1;
                r_q    <= q_next;
                r_dcnt <= r_dcnt - DCW'(1);
                if (r_dcnt == '0) begin
                    if (!r_phase) r_fwd[r_ib] <= q_val;
                    else          r_rgt[r_ib] <= q_val;
                    r_ib <= r_ib + 2'd1;
                end
            end
            B_NEXT: begin
                r_ia  <= 2'd0;
                r_ib  <= 2'd0;
                r_sub <= 1'b0;
            end
            B_CROSS: begin
                // Pairs of products per component
                r_sub <= ~r_sub;
                if (!r_sub) begin
                    r_prod <= $signed(prod[ACW-1:0]);
                end else if (!r_ib[0]) begin
                    r_acc <= r_prod;
                    r_ib  <= 2'd1;
                end else begin
                    if (!r_phase) r_cr[r_ia]  <= acc_dif;
                    else          r_upn[r_ia] <= clamp_one(round_frac(acc_dif));
                    r_ib <= 2'd0;
                    r_ia <= (r_ia == 2'd2) ? 2'd0 : r_ia + 2'd1;
                end
            end
            B_CROSSLD: begin
                r_phase <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_nm[i] <= NMW'(mag_acc(r_cr[i]));
                    r_ns[i] <= r_cr[i][ACW-1];
                end
            end
            B_DOT: begin
                // Dot of the eye with each axis
                r_sub <= ~r_sub;
                if (!r_sub) begin
                    r_prod <= $signed(prod[ACW-1:0]);
                end else begin
                    r_acc <= acc_sum;
                    if (r_ib == 2'd2) begin
                        r_tr[r_ia] <= sat_dw(round_frac(-acc_sum));
                        r_ib <= 2'd0;
                        r_ia <= r_ia + 2'd1;
                    end else begin
                        r_ib <= r_ib + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output buffer: rows drain while the next item is worked on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_row      <= 2'd0;
        end else if (r_state == B_DONE && ob_free) begin
            r_ob_valid <= 1'b1;
            r_row      <= 2'd0;
        end else if (r_ob_valid && i_ready) begin
            if (r_row == 2'd3) r_ob_valid <= 1'b0;
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_DONE && ob_free) begin
            r_orgt <= r_rgt;
            r_oupn <= r_upn;
            r_ofwd <= r_fwd;
            r_otr  <= r_tr;
        end
    end

    // Row selection
    always_comb begin
        if (r_row == 2'd3) begin
            o_data = {DATA_WIDTH'(ONE_A), r_otr[2], r_otr[1], r_otr[0]};
        end else begin
            o_data = {{DATA_WIDTH{1'b0}},
                      DATA_WIDTH'(r_ofwd[r_row]),
                      DATA_WIDTH'(r_oupn[r_row]),
                      DATA_WIDTH'(r_orgt[r_row])};
        end
    end

    assign o_valid = r_ob_valid;
    assign o_row   = r_row;
    assign o_last  = (r_row == 2'd3);

endmodule

[sv/look_at_view_matrix.sv]
// Look-at view matrix: each input item (eye, target, up in signed Q16.16)
// gives four result items, the rows (right.x, upn.x, fwd.x, 0) ..
// (right.z, upn.z, fwd.z, 0) and (tx, ty, tz, 1.0); tuser carries the row
// number and tlast marks the fourth row. The handedness register (0 forward
// is target minus eye, 1 eye minus target) is written through i_cfg_wr_en.
// The back end works an item through one shared 34x34 multiplier, a
// bit-serial square root of 32 steps and a restoring divider of 18 steps
// per component, each run once for the forward and once for the right
// axis; the root and the divider are skipped for an axis that comes out
// zero, as when eye and target coincide. A two-entry queue and a holding
// stage take up to three further items meanwhile, and the four rows drain
// from their own buffer while the next item is computed.
module look_at_view_matrix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // col_zero, col_one, col_two, col_three
    output logic [127:0] m_axis_tdata,
    // row_index
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import llv_pkg::*;

    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    llv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .o_valid       (f_valid),
        .i_ready       (f_ready),
        .o_item        (f_item)
    );

    llv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    llv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_row   (m_axis_tuser),
        .o_last  (m_axis_tlast),
        .o_data  (m_axis_tdata)
    );

endmodule

[tb/sv/tb_look_at_view_matrix.sv]
`timescale 1ns / 100ps

module tb_look_at_view_matrix;
    import llv_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  RST_CYCLES  = 8;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  SETTLE      = 320;
    localparam int  N_RANDOM    = 400;

    typedef logic signed [63:0] vec3_t [0:2];
    typedef logic [DATA_WIDTH-1:0] item_t [0:8];

    typedef struct {
        logic [1:0]            row;
        logic [DATA_WIDTH-1:0] col [0:3];
        logic                  last;
    } row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_wr_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    row_t   rows_due [$];
    logic   handed = 1'b0;
    int     n_errors = 0;
    int     n_items = 0;
    int     n_rows = 0;
    int     cycles = 0;
    bit     gaps_on = 1'b1;
    bit     stalls_on = 1'b1;
    int     hold_cycles = 0;

    look_at_view_matrix u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Unit vector at FRAC_BITS; zero stays zero
    function automatic vec3_t unit_vec(input vec3_t v);
        vec3_t       r;
        logic [63:0] m [0:2];
        logic [63:0] top;
        logic [63:0] len;
        logic [63:0] q;
        for (int i = 0; i < 3; i++) m[i] = mag64(v[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (top == 0) begin
            for (int i = 0; i < 3; i++) r[i] = 0;
            return r;
        end
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            r[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return r;
    endfunction

    function automatic vec3_t cross_vec(input vec3_t a, input vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic logic signed [63:0] drop_frac(input logic signed [63:0] x);
        logic [63:0] m;
        m = (mag64(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clip_word(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[DATA_WIDTH-1:0];
    endfunction

    // Queue the four matrix rows for one accepted item
    task automatic queue_matrix(input item_t it);
        vec3_t eye, tgt, up, d, fwd, rgt, upn, tr;
        logic signed [63:0] one;
        logic signed [63:0] u;
        row_t r;
        one = 64'sd1 <<< FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            eye[i] = $signed(it[i]);
            tgt[i] = $signed(it[3 + i]);
            up[i]  = $signed(it[6 + i]);
            d[i]   = handed ? eye[i] - tgt[i] : tgt[i] - eye[i];
        end
        fwd = unit_vec(d);
        rgt = unit_vec(cross_vec(up, fwd));
        upn = cross_vec(fwd, rgt);
        for (int i = 0; i < 3; i++) begin
            u = drop_frac(upn[i]);
            upn[i] = u > one ? one : (u < -one ? -one : u);
        end
        tr[0] = -(eye[0] * rgt[0] + eye[1] * rgt[1] + eye[2] * rgt[2]);
        tr[1] = -(eye[0] * upn[0] + eye[1] * upn[1] + eye[2] * upn[2]);
        tr[2] = -(eye[0] * fwd[0] + eye[1] * fwd[1] + eye[2] * fwd[2]);
        for (int k = 0; k < 4; k++) begin
            r.row  = k[1:0];
            r.last = (k == 3);
            if (k < 3) begin
                r.col[0] = clip_word(rgt[k]);
                r.col[1] = clip_word(upn[k]);
                r.col[2] = clip_word(fwd[k]);
                r.col[3] = '0;
            end else begin
                r.col[0] = clip_word(drop_frac(tr[0]));
                r.col[1] = clip_word(drop_frac(tr[1]));
                r.col[2] = clip_word(drop_frac(tr[2]));
                r.col[3] = clip_word(one);
            end
            rows_due.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // Offer one item and wait until it is taken
    task automatic send_item(input item_t it);
        logic [287:0] flat;
        int gap;
        for (int i = 0; i < 9; i++) flat[i*DATA_WIDTH +: DATA_WIDTH] = it[i];
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= flat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        queue_matrix(it);
        n_items++;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_handedness(input logic v);
        go_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        handed = v;
    endtask

    // Receiver: per-row stall, plus an occasional long hold-off
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            n = stalls_on ? $urandom_range(0, 15) : 0;
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report(input string what, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        n_errors++;
        $display("MISMATCH %s: expected %h got %h (row item %0d)", what, exp_v, got_v,
                 n_rows);
    endtask

    always @(posedge i_clk) begin
        row_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rows_due.size() == 0) begin
                report("unexpected row", '0, {30'd0, m_axis_tuser});
            end else begin
                e = rows_due.pop_front();
                if (m_axis_tuser != e.row) report("row_index", e.row, m_axis_tuser);
                if (m_axis_tlast != e.last) report("last_row", e.last, m_axis_tlast);
                for (int c = 0; c < 4; c++)
                    if (m_axis_tdata[c*32 +: 32] != e.col[c])
                        report($sformatf("col %0d", c), e.col[c], m_axis_tdata[c*32 +: 32]);
            end
            n_rows++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [31:0] pick_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        endcase
    endfunction

    function automatic item_t mk(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                 ux, uy, uz);
        item_t it;
        it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        return it;
    endfunction

    task automatic test_directed();
        logic [31:0] one, mx, mn;
        one = 32'h0001_0000;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        // usual camera, opposite extremes, zero everything
        send_item(mk(0, 0, 0, 0, 0, one, 0, one, 0));
        send_item(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_item(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_item(mk(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        send_item(mk(mx, mn, mx, mn, mx, mn, mn, mx, mn));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // eye equal to target: zero forward axis
        send_item(mk(one, 2*one, 3*one, one, 2*one, 3*one, 0, one, 0));
        // up parallel to forward: zero right and up axes
        send_item(mk(0, 0, 0, 0, 5*one, 0, 0, one, 0));
        send_item(mk(one, one, one, 3*one, 3*one, 3*one, mn, mn, mn));
        // zero up
        send_item(mk(one, 0, 0, 0, one, 0, 0, 0, 0));
        // large eye far from a nearby target: translation saturates
        send_item(mk(mx, mx, mn, 0, 0, 0, 0, one, 0));
        send_item(mk(mn, mx, mx, mx, 0, 1, 1, 0, 0));
        // one-lsb vectors
        send_item(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_item(mk(1, 1, 1, 0, 0, 0, 32'hffff_ffff, 0, 1));
    endtask

    task automatic test_random(input int count);
        item_t it;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) it[i] = pick_word(kind);
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) it[3 + i] = it[i];   // eye on target
                1: for (int i = 0; i < 3; i++) it[6 + i] = it[3 + i] - it[i]; // up along view
                2: for (int i = 0; i < 3; i++) it[6 + i] = pick_word(0);
                default: ;
            endcase
            send_item(it);
        end
    endtask

    task automatic test_handedness();
        write_handedness(1'b1);
        test_directed();
        test_random(30);
        write_handedness(1'b0);
        test_random(30);
        write_handedness(1'b1);
    endtask

    // Receiver held off while items keep coming: input must stall
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_cycles = 2500;
        test_random(10);
        gaps_on = 1'b1;
        // sender pauses until the block has drained
        go_idle();
        test_random(5);
        go_idle();
        stalls_on = 1'b0;
        gaps_on = 1'b0;
        test_random(20);
        stalls_on = 1'b1;
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(N_RANDOM / 2);
        test_handedness();
        test_backpressure();
        write_handedness(1'b0);
        test_random(N_RANDOM / 2 - 100);
        s_axis_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d view set-ups in both handedness modes, checked %0d rows", n_items,
                 n_rows);
        $display("Covered field extremes, coincident eye and target, parallel up, stalls");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
